/* hdl/hbp_pkg.sv */
// Shared types and constants for the RTPS HEARTBEAT submessage parser.
package hbp_pkg;

	localparam int unsigned ID_W = 32;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_TDATA_W = 24;

	typedef logic [CNT_W-1:0] hbp_cnt_t;

	// Byte counter saturation point
	localparam hbp_cnt_t COUNT_MAX = 5'd31;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PUB_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUB_ID = 2'd1;

	// Register reset values (builtin reader entity ids)
	localparam logic [ID_W-1:0] PUB_ID_RST = 32'h0000_03C7;
	localparam logic [ID_W-1:0] SUB_ID_RST = 32'h0000_04C7;

	// Both match flags set
	localparam logic [1:0] FLAGS_ALL = 2'b11;

	typedef struct packed {
		logic [ID_W-1:0] pub_id;
		logic [ID_W-1:0] sub_id;
	} hbp_cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_mark;
		logic       byte_valid;
	} hbp_item_t;

	typedef struct packed {
		logic [7:0] last_seq_low;
		logic [7:0] first_seq_low;
		logic [1:0] match_type;
	} hbp_result_t;

	// Byte of an entity id at readerId position pos; position 0 is the top byte
	function automatic logic [7:0] id_byte(input logic [ID_W-1:0] id, input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = id[31:24];
			2'd1: b = id[23:16];
			2'd2: b = id[15:8];
			2'd3: b = id[7:0];
			default: b = id[7:0];
		endcase
		return b;
	endfunction

endpackage

/* hdl/hbp_cfg_regs.sv */
// Configuration registers holding the two builtin reader entity ids.
module hbp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hbp_pkg::ID_W-1:0]       cfg_data,
	output hbp_pkg::hbp_cfg_t              cfg
);
	import hbp_pkg::*;

	logic [ID_W-1:0] pub_id_q;
	logic [ID_W-1:0] sub_id_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_id_q <= PUB_ID_RST;
			sub_id_q <= SUB_ID_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PUB_ID: pub_id_q <= cfg_data;
				CFG_SUB_ID: sub_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.pub_id = pub_id_q;
	assign cfg.sub_id = sub_id_q;

endmodule

/* hdl/hbp_parse.sv */
// Parse state and single-pass next-state logic for one byte item.
module hbp_parse #(
	parameter int unsigned HEADER_BYTES = 4,
	parameter int unsigned FLAGS_POS    = 1,
	parameter int unsigned BODY_BYTES   = 28,
	parameter int unsigned FIRST_SN_POS = 8,
	parameter int unsigned LAST_SN_POS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  hbp_pkg::hbp_item_t    item,
	input  hbp_pkg::hbp_cfg_t     cfg,
	output hbp_pkg::hbp_result_t  res
);
	import hbp_pkg::*;

	localparam hbp_cnt_t HEADER_C   = CNT_W'(HEADER_BYTES);
	localparam hbp_cnt_t FLAGS_C    = CNT_W'(FLAGS_POS);
	localparam hbp_cnt_t BODY_C     = CNT_W'(BODY_BYTES);
	localparam hbp_cnt_t FIRST_LE_C = CNT_W'(FIRST_SN_POS + 4);
	localparam hbp_cnt_t FIRST_BE_C = CNT_W'(FIRST_SN_POS + 7);
	localparam hbp_cnt_t LAST_LE_C  = CNT_W'(LAST_SN_POS + 4);
	localparam hbp_cnt_t LAST_BE_C  = CNT_W'(LAST_SN_POS + 7);

	logic       in_body_q, in_body_d;
	hbp_cnt_t   cnt_q, cnt_d;
	logic       le_q, le_d;
	logic [1:0] flags_q, flags_d;
	logic [7:0] first_q, first_d;
	logic [7:0] last_q, last_d;
	logic [1:0] match_out;
	hbp_cnt_t   cnt_inc;
	hbp_cnt_t   fpos;
	hbp_cnt_t   lpos;
	logic       in_id;
	logic       pub_mis;
	logic       sub_mis;

	// readerId compare and sequence byte positions
	assign in_id   = (cnt_q[CNT_W-1:2] == '0);
	assign pub_mis = in_id && (id_byte(cfg.pub_id, cnt_q[1:0]) != item.in_byte);
	assign sub_mis = in_id && (id_byte(cfg.sub_id, cnt_q[1:0]) != item.in_byte);
	assign fpos    = le_q ? FIRST_LE_C : FIRST_BE_C;
	assign lpos    = le_q ? LAST_LE_C : LAST_BE_C;
	assign cnt_inc = (cnt_q < COUNT_MAX) ? cnt_q + 5'd1 : cnt_q;

	// Next state for the item
	always_comb begin
		in_body_d = in_body_q;
		cnt_d     = cnt_q;
		le_d      = le_q;
		flags_d   = flags_q;
		first_d   = first_q;
		last_d    = last_q;
		match_out = 2'b00;
		if (item.byte_valid) begin
			if (!in_body_q) begin
				if (cnt_q == FLAGS_C) begin
					le_d = item.in_byte[0];
				end
				if (cnt_inc == HEADER_C) begin
					cnt_d     = '0;
					in_body_d = 1'b1;
				end else begin
					cnt_d = cnt_inc;
				end
			end else begin
				flags_d = flags_q & ~{sub_mis, pub_mis};
				if (cnt_q < COUNT_MAX) begin
					if (cnt_q == fpos) begin
						first_d = item.in_byte;
					end else if (cnt_q == lpos) begin
						last_d = item.in_byte;
					end
					cnt_d = cnt_inc;
					if (cnt_inc == BODY_C) begin
						match_out = flags_d;
					end
				end
			end
		end
		// End mark restarts the parse
		if (item.last_mark) begin
			in_body_d = 1'b0;
			cnt_d     = '0;
			flags_d   = FLAGS_ALL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			cnt_q     <= '0;
			le_q      <= 1'b0;
			flags_q   <= FLAGS_ALL;
			first_q   <= '0;
			last_q    <= '0;
		end else if (step) begin
			in_body_q <= in_body_d;
			cnt_q     <= cnt_d;
			le_q      <= le_d;
			flags_q   <= flags_d;
			first_q   <= first_d;
			last_q    <= last_d;
		end
	end

	assign res.match_type    = match_out;
	assign res.first_seq_low = first_d;
	assign res.last_seq_low  = last_d;

`ifndef SYNTH
	// End mark leaves a fresh header phase
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.last_mark) |=> (!in_body_q && cnt_q == '0 && flags_q == FLAGS_ALL))
		else $error("parse not restarted after end mark");

	// Header counter never reaches the header length
	a_hdr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!in_body_q |-> (cnt_q < HEADER_C))
		else $error("header count out of range");

	// A non-byte item reports no match
	a_invalid_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		!item.byte_valid |-> (res.match_type == 2'b00))
		else $error("match reported on invalid byte");
`endif

endmodule

/* hdl/rtps_heartbeat_submessage_parser.sv */
// Top level: stream ports, input register, parse stage and result register.
// Items pass the input register, then the parse stage, into the result register.
// Throughput: one item per cycle while m_tready keeps the result register draining;
// the parse state updates once per item. While a result waits, the input register
// takes one more item, then input stalls. Reset (arst_n low, asynchronous): pipeline
// empty, parse in header phase, match flags set, sequence bytes zero, reader ids at builtin defaults.
module rtps_heartbeat_submessage_parser #(
	parameter int unsigned HEADER_BYTES = 4,
	parameter int unsigned FLAGS_POS    = 1,
	parameter int unsigned BODY_BYTES   = 28,
	parameter int unsigned FIRST_SN_POS = 8,
	parameter int unsigned LAST_SN_POS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // in_byte
	input  logic                                s_tlast,  // last_mark
	input  logic                                s_tuser,  // byte_valid
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// match_type[1:0], first_seq_low[9:2], last_seq_low[17:10], zero pad
	output logic [hbp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hbp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hbp_pkg::ID_W-1:0]            cfg_data
);
	import hbp_pkg::*;

	hbp_cfg_t    cfg;
	hbp_item_t   item_s1;
	logic        valid_s1;
	hbp_result_t res;
	hbp_result_t res_q;
	logic        out_valid_q;
	logic        out_adv;
	logic        step;

	hbp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline flow control
	assign out_adv  = !out_valid_q || m_tready;
	assign step     = valid_s1 && out_adv;
	assign s_tready = !valid_s1 || out_adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.in_byte    <= s_tdata;
			item_s1.last_mark  <= s_tlast;
			item_s1.byte_valid <= s_tuser;
		end
	end

	hbp_parse #(
		.HEADER_BYTES (HEADER_BYTES),
		.FLAGS_POS    (FLAGS_POS),
		.BODY_BYTES   (BODY_BYTES),
		.FIRST_SN_POS (FIRST_SN_POS),
		.LAST_SN_POS  (LAST_SN_POS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - $bits(hbp_result_t))'(0), res_q};

`ifndef SYNTH
	// Full pipeline with a stalled result blocks input
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while pipeline full");

	// A parsed item always lands in the result register
	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("parsed item lost");

	// With the result side free, the input side is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty result register");
`endif

endmodule

/* test/tb_top.sv */
// Testbench for the RTPS HEARTBEAT submessage parser: directed table, random packets, scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hbp_pkg::*;

	localparam int HDR_BYTES    = 4;
	localparam int FLAGS_BYTE   = 1;
	localparam int BODY_LEN     = 28;
	localparam int FIRST_SN_OFS = 8;
	localparam int LAST_SN_OFS  = 16;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	localparam int BYTE_TARGET  = 1150;
	localparam int NUM_PHASES   = 5;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 6;
	localparam int LIMIT_CYCLES = 200000;

	// indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef enum int {PKT_GOOD, PKT_SHORT, PKT_LONG, PKT_NOISE} pkt_kind_t;

	// one directed item; typed = 1 means the expected result is given in the row
	typedef struct packed {
		logic [7:0] b;
		logic       eop;
		logic       vld;
		logic       typed;
		logic [1:0] mt;
		logic [7:0] seq_first;
		logic [7:0] seq_last;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;  // in_byte
	logic s_tlast;        // last_mark
	logic s_tuser;        // byte_valid
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;  // match_type, first_seq_low, last_seq_low, zero pad
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ID_W-1:0] cfg_data;

	// predictor state
	logic [ID_W-1:0] hb_pub_id;
	logic [ID_W-1:0] hb_sub_id;
	logic            hb_in_body;
	logic [CNT_W-1:0] hb_count;
	logic            hb_le;
	logic [1:0]      hb_flags;
	logic [7:0]      hb_first;
	logic [7:0]      hb_last;

	hbp_result_t exp_results[$];
	int items_sent = 0;
	int err_cnt = 0;
	int unsigned cycle_cnt = 0;
	logic idle_on = 1'b1;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	dir_row_t dir_rows [0:21] = '{
		'{8'h00, 1'b0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // invalid byte, ignored
		'{8'hFF, 1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},  // invalid byte, end mark still applies
		'{8'hFF, 1'b1, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},  // valid byte with end mark
		'{8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},  // header
		'{8'hFF, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},  // flags: little endian
		'{8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
		'{8'h80, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},  // header done
		'{8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},  // readerId, matches sub only
		'{8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
		'{8'h04, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
		'{8'hC7, 1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00},
		'{8'h11, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h22, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h5A, 1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},  // invalid byte inside the body
		'{8'h33, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h44, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h55, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h66, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h77, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'h88, 1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
		'{8'hA5, 1'b0, 1'b1, 1'b1, 2'd0, 8'hA5, 8'h00},  // firstSN low byte, little endian
		'{8'h01, 1'b1, 1'b1, 1'b1, 2'd0, 8'hA5, 8'h00}   // end mark keeps sequence bytes
	};

	rtps_heartbeat_submessage_parser #(
		.HEADER_BYTES(HDR_BYTES),
		.FLAGS_POS(FLAGS_BYTE),
		.BODY_BYTES(BODY_LEN),
		.FIRST_SN_POS(FIRST_SN_OFS),
		.LAST_SN_POS(LAST_SN_OFS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// parse one byte and return the result item it causes
	function automatic hbp_result_t predict_heartbeat_byte(input logic [7:0] b, input logic eop,
			input logic vld);
		hbp_result_t r;
		logic [1:0] mt;
		int fpos;
		int lpos;
		mt = 2'd0;
		if (vld) begin
			if (!hb_in_body) begin
				if (hb_count == FLAGS_BYTE) hb_le = b[0];
				if (hb_count != COUNT_MAX) hb_count = hb_count + 1'b1;
				if (hb_count == HDR_BYTES) begin
					hb_count = '0;
					hb_in_body = 1'b1;
				end
			end else begin
				fpos = FIRST_SN_OFS + (hb_le ? 4 : 7);
				lpos = LAST_SN_OFS + (hb_le ? 4 : 7);
				// readerId bytes, most significant byte of the id first
				if (hb_count < 4) begin
					if (hb_pub_id[8 * (3 - hb_count) +: 8] != b) hb_flags[0] = 1'b0;
					if (hb_sub_id[8 * (3 - hb_count) +: 8] != b) hb_flags[1] = 1'b0;
				end
				if (hb_count != COUNT_MAX) begin
					if (hb_count == fpos) hb_first = b;
					else if (hb_count == lpos) hb_last = b;
					hb_count = hb_count + 1'b1;
					if (hb_count == BODY_LEN) mt = hb_flags;
				end
			end
		end
		if (eop) begin
			hb_in_body = 1'b0;
			hb_count = '0;
			hb_flags = 2'b11;
		end
		r.match_type = mt;
		r.first_seq_low = hb_first;
		r.last_seq_low = hb_last;
		return r;
	endfunction

	// offer one item, wait for it to be taken, then queue what it should produce
	task automatic send_byte(input logic [7:0] b, input logic eop, input logic vld,
			input logic typed, input hbp_result_t typed_res);
		hbp_result_t pred;
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eop;
		s_tuser <= vld;
		do @(posedge clk); while (!s_tready);
		pred = predict_heartbeat_byte(b, eop, vld);
		exp_results.push_back(typed ? typed_res : pred);
		items_sent++;
	endtask

	// one submessage: well-formed, cut short, overlong or plain noise
	task automatic send_packet(input pkt_kind_t kind);
		logic [31:0] rid;
		logic [7:0] b;
		logic eop;
		logic vld;
		int total;
		int k;
		case ($urandom_range(0, 3))
			0: rid = hb_pub_id;
			1: rid = hb_sub_id;
			2: rid = $urandom;
			default: begin
				// one byte off from the publications id
				rid = hb_pub_id;
				k = $urandom_range(0, 3);
				rid[8 * k +: 8] = rid[8 * k +: 8] ^ 8'($urandom_range(1, 255));
			end
		endcase
		case (kind)
			PKT_GOOD:  total = HDR_BYTES + BODY_LEN;
			PKT_SHORT: total = $urandom_range(1, HDR_BYTES + BODY_LEN - 1);
			PKT_LONG:  total = HDR_BYTES + BODY_LEN + $urandom_range(1, 12);
			default:   total = $urandom_range(1, 20);
		endcase
		for (int i = 0; i < total; i++) begin
			b = 8'($urandom);
			if (kind == PKT_NOISE) begin
				vld = ($urandom_range(0, 3) != 0);
				eop = (i == total - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
			end else begin
				if (i >= HDR_BYTES && i < HDR_BYTES + 4) b = rid[8 * (3 - (i - HDR_BYTES)) +: 8];
				vld = 1'b1;
				eop = (i == total - 1);
				if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
			end
			send_byte(b, eop, vld, 1'b0, '0);
		end
	endtask

	// register write; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_PUB_ID) hb_pub_id = val;
		else if (idx == CFG_SUB_ID) hb_sub_id = val;
	endtask

	// stop offering and wait until every expected result is out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
		hbp_result_t got;
		hbp_result_t want;
		got = word[$bits(hbp_result_t)-1:0];
		if (exp_results.size() == 0) begin
			$error("result item with nothing expected: %h", word);
			err_cnt++;
		end else begin
			want = exp_results.pop_front();
			if (got.match_type !== want.match_type) begin
				$error("match_type: expected %0d, actual %0d", want.match_type, got.match_type);
				err_cnt++;
			end
			if (got.first_seq_low !== want.first_seq_low) begin
				$error("first_seq_low: expected %h, actual %h", want.first_seq_low,
					got.first_seq_low);
				err_cnt++;
			end
			if (got.last_seq_low !== want.last_seq_low) begin
				$error("last_seq_low: expected %h, actual %h", want.last_seq_low, got.last_seq_low);
				err_cnt++;
			end
		end
	endtask

	// result side: check taken items, then pick tready for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) check_result(m_tdata);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("rtps_heartbeat_submessage_parser test failed");
			$finish;
		end
	end

	initial begin
		hbp_result_t want;
		pkt_kind_t kind;
		int pick;
		logic [ID_W-1:0] shared_id;
		logic hold_fired;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_fired = 1'b0;
		hb_pub_id = 32'h0000_03C7;
		hb_sub_id = 32'h0000_04C7;
		hb_in_body = 1'b0;
		hb_count = '0;
		hb_le = 1'b0;
		hb_flags = 2'b11;
		hb_first = '0;
		hb_last = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// new register settings, only with the block idle
			if (phase != 0) begin
				wait_drained();
				case (phase)
					1: begin
						write_reg(CFG_PUB_ID, 32'hFFFF_FFFF);
						write_reg(CFG_SUB_ID, 32'h0000_0000);
					end
					2: begin
						// same id twice, so both flags can match at once
						shared_id = $urandom;
						write_reg(CFG_PUB_ID, shared_id);
						write_reg(CFG_SUB_ID, shared_id);
					end
					3: begin
						write_reg(CFG_SPARE_2, $urandom);
						write_reg(CFG_PUB_ID, $urandom);
						write_reg(CFG_SUB_ID, $urandom);
						write_reg(CFG_SPARE_3, $urandom);
					end
					default: begin
						write_reg(CFG_PUB_ID, 32'h0000_0000);
						write_reg(CFG_SUB_ID, 32'hFFFF_FFFF);
					end
				endcase
				cfg_valid <= 1'b0;
			end

			if (phase == 0) begin
				for (int r = 0; r < $size(dir_rows); r++) begin
					want.match_type = dir_rows[r].mt;
					want.first_seq_low = dir_rows[r].seq_first;
					want.last_seq_low = dir_rows[r].seq_last;
					send_byte(dir_rows[r].b, dir_rows[r].eop, dir_rows[r].vld, dir_rows[r].typed,
						want);
				end
			end

			while (items_sent < (phase + 1) * BYTE_TARGET / NUM_PHASES) begin
				// last phase runs without idling on either side
				idle_on <= (phase < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
				// long receiver hold while the sender keeps going
				if (phase == 1 && !hold_fired) begin
					hold_toggle <= ~hold_toggle;
					hold_fired = 1'b1;
				end
				pick = $urandom_range(0, 19);
				if (pick < 12) kind = PKT_GOOD;
				else if (pick < 15) kind = PKT_SHORT;
				else if (pick < 18) kind = PKT_LONG;
				else kind = PKT_NOISE;
				send_packet(kind);
			end
		end

		wait_drained();
		if (err_cnt == 0) begin
			$display("rtps_heartbeat_submessage_parser test passed");
		end else begin
			$display("rtps_heartbeat_submessage_parser test failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/hbp_pkg.sv
hdl/hbp_cfg_regs.sv
hdl/hbp_parse.sv
hdl/rtps_heartbeat_submessage_parser.sv
test/tb_top.sv
